@@ rtl/core/abrm_pkg.sv @@
package abrm_pkg;

    localparam int FRAC_BITS = 12;
    localparam int IN_BITS   = 16;
    localparam int R2_BITS   = 32;
    localparam int D_BITS    = 32;
    localparam int SQ_BITS   = 56;
    localparam int Q_BITS    = 28;
    localparam int UNIT_BITS = 14;
    localparam int NUM_BITS  = 41;
    localparam int ACC_BITS  = 48;

    typedef logic signed [IN_BITS-1:0]   field_t;
    typedef logic signed [UNIT_BITS-1:0] unit_t;

    typedef struct packed {
        unit_t c;
        unit_t s;
        unit_t x;
        unit_t y;
        unit_t z;
    } unit_set_t;

endpackage

@@ rtl/core/abrm_isqrt.sv @@
// pipelined restoring integer square root, one result bit per stage
module abrm_isqrt
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [abrm_pkg::SQ_BITS-1:0]  rad,
    output logic [abrm_pkg::Q_BITS-1:0]   root
);
    import abrm_pkg::*;

    localparam int STEPS = Q_BITS;

    logic [SQ_BITS-1:0] rem_reg  [STEPS+1];
    logic [SQ_BITS-1:0] rad_reg  [STEPS+1];
    logic [Q_BITS-1:0]  res_reg  [STEPS+1];

    always_comb
    begin
        rem_reg[0] = '0;
        rad_reg[0] = rad;
        res_reg[0] = '0;
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic [SQ_BITS+1:0] rem_next;
        logic [SQ_BITS+1:0] trial;
        logic [SQ_BITS-1:0] r_q;
        logic [SQ_BITS-1:0] a_q;
        logic [Q_BITS-1:0]  s_q;

        // shift in two radicand bits, try subtracting 4*root+1
        always_comb
        begin
            rem_next = {rem_reg[i], rad_reg[i][SQ_BITS-1:SQ_BITS-2]};
            trial    = rem_next - {{(SQ_BITS-Q_BITS){1'b0}}, res_reg[i], 2'b01};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_q <= {rad_reg[i][SQ_BITS-3:0], 2'b00};
                if (!trial[SQ_BITS+1])
                begin
                    r_q <= trial[SQ_BITS-1:0];
                    s_q <= {res_reg[i][Q_BITS-2:0], 1'b1};
                end
                else
                begin
                    r_q <= rem_next[SQ_BITS-1:0];
                    s_q <= {res_reg[i][Q_BITS-2:0], 1'b0};
                end
            end
        end

        assign rem_reg[i+1] = r_q;
        assign rad_reg[i+1] = a_q;
        assign res_reg[i+1] = s_q;
    end

    assign root = res_reg[STEPS];

endmodule

@@ rtl/core/abrm_rdiv.sv @@
// pipelined rounded signed division num / den, ties away from zero
module abrm_rdiv
(
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [abrm_pkg::NUM_BITS-1:0] num,
    input  logic        [abrm_pkg::Q_BITS-1:0]   den,
    output abrm_pkg::unit_t                      quo
);
    import abrm_pkg::*;

    // |quotient| <= 4096 so 14 quotient bits suffice
    localparam int STEPS = UNIT_BITS;
    localparam int W     = Q_BITS + 2;

    logic [W-1:0]        rem_w [STEPS+1];
    logic [NUM_BITS-1:0] mag_w [STEPS+1];
    logic [Q_BITS-1:0]   den_w [STEPS+1];
    logic [STEPS-1:0]    q_w   [STEPS+1];
    logic                neg_w [STEPS+1];

    logic [NUM_BITS-1:0] mag0;
    logic [NUM_BITS:0]   mag_r;

    // rounding: (|num| + den/2) / den, shifted by STEPS for the bits we keep
    always_comb
    begin
        mag0  = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
        mag_r = {1'b0, mag0} + {{(NUM_BITS-Q_BITS+2){1'b0}}, den[Q_BITS-1:1]};
        rem_w[0] = W'(mag_r >> STEPS);
        mag_w[0] = mag_r[NUM_BITS-1:0] << (NUM_BITS - STEPS);
        den_w[0] = den;
        q_w[0]   = '0;
        neg_w[0] = num[NUM_BITS-1];
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic [W:0]          sh;
        logic [W:0]          tr;
        logic [W-1:0]        r_q;
        logic [NUM_BITS-1:0] m_q;
        logic [Q_BITS-1:0]   d_q;
        logic [STEPS-1:0]    q_q;
        logic                n_q;

        always_comb
        begin
            sh = {rem_w[i], mag_w[i][NUM_BITS-1]};
            tr = sh - {3'b000, den_w[i]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_q <= mag_w[i] << 1;
                d_q <= den_w[i];
                n_q <= neg_w[i];
                if (!tr[W])
                begin
                    r_q <= tr[W-1:0];
                    q_q <= {q_w[i][STEPS-2:0], 1'b1};
                end
                else
                begin
                    r_q <= sh[W-1:0];
                    q_q <= {q_w[i][STEPS-2:0], 1'b0};
                end
            end
        end

        assign rem_w[i+1] = r_q;
        assign mag_w[i+1] = m_q;
        assign den_w[i+1] = d_q;
        assign q_w[i+1]   = q_q;
        assign neg_w[i+1] = n_q;
    end

    assign quo = neg_w[STEPS] ? unit_t'(-q_w[STEPS]) : unit_t'(q_w[STEPS]);

endmodule

@@ rtl/core/abrm_entry.sv @@
// one matrix entry: uu*4096 + c*(diag - uu) + s*k*4096, rounded and saturated
module abrm_entry #(
    parameter int WORD_BITS = 16
)
(
    input  logic            clk,
    input  logic            en,
    input  abrm_pkg::unit_t ui,
    input  abrm_pkg::unit_t uj,
    input  logic            diag,
    input  abrm_pkg::unit_t c,
    input  abrm_pkg::unit_t s,
    input  abrm_pkg::unit_t k,
    output abrm_pkg::field_t res
);
    import abrm_pkg::*;

    logic signed [27:0] uu_reg, sk_reg;
    logic signed [UNIT_BITS-1:0] c1_reg;
    logic signed [28:0] dm;
    logic signed [ACC_BITS-1:0] acc_reg;
    logic signed [ACC_BITS-1:0] acc_next;
    logic [ACC_BITS-1:0] mag;
    logic [ACC_BITS-1:0] rq;
    logic signed [ACC_BITS-1:0] v;
    logic signed [ACC_BITS-1:0] hi, lo;
    field_t res_reg;

    // stage 1: products of unit parts
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            uu_reg <= 28'(ui * uj);
            sk_reg <= 28'(s * k);
            c1_reg <= c;
        end
    end

    // stage 2: combine in Q.36
    always_comb
    begin
        dm = (diag ? 29'sd16777216 : 29'sd0) - 29'(uu_reg);
        acc_next = (ACC_BITS'(uu_reg) <<< 12) + ACC_BITS'(c1_reg * dm)
                   + (ACC_BITS'(sk_reg) <<< 12);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            acc_reg <= acc_next;
    end

    // stage 3: round half away from zero, saturate
    always_comb
    begin
        hi  = ACC_BITS'((64'sd1 <<< (WORD_BITS - 1)) - 1);
        lo  = -hi - 1;
        mag = acc_reg[ACC_BITS-1] ? ACC_BITS'(-acc_reg) : ACC_BITS'(acc_reg);
        rq  = (mag + (ACC_BITS'(1) << 23)) >> 24;
        v   = acc_reg[ACC_BITS-1] ? -$signed(rq) : $signed(rq);
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= v[IN_BITS-1:0];
    end

    assign res = res_reg;

endmodule

@@ rtl/core/axis_billboard_rotation_matrix.sv @@
// pipeline from input word to output word: a square stage, 28 root steps,
// 14 divide steps and 3 entry stages
// throughput: one word per clock; the whole pipeline advances when the output is free
// reset: rst_n asynchronous active low clears all valid bits; data registers are not reset
module axis_billboard_rotation_matrix #(
    parameter int WORD_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  abrm_pkg::field_t        view_m8,
    input  abrm_pkg::field_t        view_m10,
    input  abrm_pkg::field_t        axis_x,
    input  abrm_pkg::field_t        axis_y,
    input  abrm_pkg::field_t        axis_z,
    output logic                    out_valid,
    input  logic                    out_ready,
    output abrm_pkg::field_t        col0_x,
    output abrm_pkg::field_t        col0_y,
    output abrm_pkg::field_t        col0_z,
    output abrm_pkg::field_t        col1_x,
    output abrm_pkg::field_t        col1_y,
    output abrm_pkg::field_t        col1_z,
    output abrm_pkg::field_t        col2_x,
    output abrm_pkg::field_t        col2_y,
    output abrm_pkg::field_t        col2_z
);
    import abrm_pkg::*;

    localparam int LAT = 1 + Q_BITS + UNIT_BITS + 3;

    logic en;
    logic [LAT-1:0] vld_reg;

    // pipeline moves when the last stage is empty or taken
    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // stage 0: sums of squares
    field_t m8_reg, m10_reg, x_reg, y_reg, z_reg;
    logic [R2_BITS-1:0] r2_reg;
    logic [D_BITS-1:0]  d_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m8_reg  <= view_m8;
            m10_reg <= view_m10;
            x_reg   <= axis_x;
            y_reg   <= axis_y;
            z_reg   <= axis_z;
            r2_reg  <= R2_BITS'(32'(view_m8 * view_m8)) + R2_BITS'(32'(view_m10 * view_m10));
            d_reg   <= D_BITS'(33'(32'(axis_x * axis_x)) + 33'(32'(axis_y * axis_y))
                       + 33'(32'(axis_z * axis_z)));
        end
    end

    // root stage: isqrt(r2 << 24) and isqrt(d << 24), data delayed alongside
    logic [Q_BITS-1:0] qr, qd;
    abrm_isqrt u_sq_r (.clk, .en, .rad({r2_reg, 24'd0}), .root(qr));
    abrm_isqrt u_sq_d (.clk, .en, .rad({d_reg, 24'd0}), .root(qd));

    field_t dl_m8 [Q_BITS+1];
    field_t dl_m10[Q_BITS+1];
    field_t dl_x  [Q_BITS+1];
    field_t dl_y  [Q_BITS+1];
    field_t dl_z  [Q_BITS+1];
    logic   dl_rz [Q_BITS+1];
    logic   dl_dz [Q_BITS+1];

    assign dl_m8[0]  = m8_reg;
    assign dl_m10[0] = m10_reg;
    assign dl_x[0]   = x_reg;
    assign dl_y[0]   = y_reg;
    assign dl_z[0]   = z_reg;
    assign dl_rz[0]  = (r2_reg == '0);
    assign dl_dz[0]  = (d_reg == '0);

    for (genvar i = 0; i < Q_BITS; i++) begin : g_dl
        field_t a, b, cx, cy, cz;
        logic   p, q;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a  <= dl_m8[i];
                b  <= dl_m10[i];
                cx <= dl_x[i];
                cy <= dl_y[i];
                cz <= dl_z[i];
                p  <= dl_rz[i];
                q  <= dl_dz[i];
            end
        end
        assign dl_m8[i+1]  = a;
        assign dl_m10[i+1] = b;
        assign dl_x[i+1]   = cx;
        assign dl_y[i+1]   = cy;
        assign dl_z[i+1]   = cz;
        assign dl_rz[i+1]  = p;
        assign dl_dz[i+1]  = q;
    end

    // divide stage: a * 2^24 / q rounded
    unit_t dc, ds, dx, dy, dz;
    logic [Q_BITS-1:0] qr_s, qd_s;
    assign qr_s = dl_rz[Q_BITS] ? Q_BITS'(1) : qr;
    assign qd_s = dl_dz[Q_BITS] ? Q_BITS'(1) : qd;

    abrm_rdiv u_dc (.clk, .en, .num(NUM_BITS'(dl_m10[Q_BITS]) <<< 24), .den(qr_s), .quo(dc));
    abrm_rdiv u_ds (.clk, .en, .num(-(NUM_BITS'(dl_m8[Q_BITS]) <<< 24)), .den(qr_s), .quo(ds));
    abrm_rdiv u_dx (.clk, .en, .num(NUM_BITS'(dl_x[Q_BITS]) <<< 24), .den(qd_s), .quo(dx));
    abrm_rdiv u_dy (.clk, .en, .num(NUM_BITS'(dl_y[Q_BITS]) <<< 24), .den(qd_s), .quo(dy));
    abrm_rdiv u_dz (.clk, .en, .num(NUM_BITS'(dl_z[Q_BITS]) <<< 24), .den(qd_s), .quo(dz));

    // zero flags run beside the divider
    logic   fz_r [UNIT_BITS+1];
    logic   fz_d [UNIT_BITS+1];
    assign fz_r[0] = dl_rz[Q_BITS];
    assign fz_d[0] = dl_dz[Q_BITS];

    for (genvar i = 0; i < UNIT_BITS; i++) begin : g_fl
        logic  a, b;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a  <= fz_r[i];
                b  <= fz_d[i];
            end
        end
        assign fz_r[i+1] = a;
        assign fz_d[i+1] = b;
    end

    // a zero axis is all zero, so its unit parts are zero too; a zero view gives c = 4096, s = 0
    unit_set_t u;
    always_comb
    begin
        u.c = fz_r[UNIT_BITS] ? unit_t'(4096) : dc;
        u.s = fz_r[UNIT_BITS] ? unit_t'(0) : ds;
        u.x = fz_d[UNIT_BITS] ? unit_t'(0) : dx;
        u.y = fz_d[UNIT_BITS] ? unit_t'(0) : dy;
        u.z = fz_d[UNIT_BITS] ? unit_t'(0) : dz;
    end

    // nine entries
    abrm_entry #(.WORD_BITS(WORD_BITS)) u_e0 (.clk, .en, .ui(u.x), .uj(u.x), .diag(1'b1),
        .c(u.c), .s(u.s), .k(unit_t'(0)), .res(col0_x));
    abrm_entry #(.WORD_BITS(WORD_BITS)) u_e1 (.clk, .en, .ui(u.y), .uj(u.x), .diag(1'b0),
        .c(u.c), .s(u.s), .k(u.z), .res(col0_y));
    abrm_entry #(.WORD_BITS(WORD_BITS)) u_e2 (.clk, .en, .ui(u.z), .uj(u.x), .diag(1'b0),
        .c(u.c), .s(u.s), .k(-u.y), .res(col0_z));
    abrm_entry #(.WORD_BITS(WORD_BITS)) u_e3 (.clk, .en, .ui(u.x), .uj(u.y), .diag(1'b0),
        .c(u.c), .s(u.s), .k(-u.z), .res(col1_x));
    abrm_entry #(.WORD_BITS(WORD_BITS)) u_e4 (.clk, .en, .ui(u.y), .uj(u.y), .diag(1'b1),
        .c(u.c), .s(u.s), .k(unit_t'(0)), .res(col1_y));
    abrm_entry #(.WORD_BITS(WORD_BITS)) u_e5 (.clk, .en, .ui(u.z), .uj(u.y), .diag(1'b0),
        .c(u.c), .s(u.s), .k(u.x), .res(col1_z));
    abrm_entry #(.WORD_BITS(WORD_BITS)) u_e6 (.clk, .en, .ui(u.x), .uj(u.z), .diag(1'b0),
        .c(u.c), .s(u.s), .k(u.y), .res(col2_x));
    abrm_entry #(.WORD_BITS(WORD_BITS)) u_e7 (.clk, .en, .ui(u.y), .uj(u.z), .diag(1'b0),
        .c(u.c), .s(u.s), .k(-u.x), .res(col2_y));
    abrm_entry #(.WORD_BITS(WORD_BITS)) u_e8 (.clk, .en, .ui(u.z), .uj(u.z), .diag(1'b1),
        .c(u.c), .s(u.s), .k(unit_t'(0)), .res(col2_z));

    assign out_valid = vld_reg[LAT-1];

    // checks
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(col0_x) && $stable(col2_z))
        else $error("output word changed while stalled");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved during stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

endmodule
